### hw/rtl/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB conversion pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // hue range: 360 degrees times 128, one sector is 60 degrees
    localparam logic [15:0] HUE_FULL   = 16'd46080;
    localparam logic [15:0] HUE_SECTOR = 16'd7680;

    // unsigned Q0.16 one
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // f = floor(rem * 65536 / 7680) = floor(rem * 128 / 15)
    // done as (rem * ceil(2^24 / 15)) >> 17, exact for rem below 7680
    localparam logic [20:0] FRAC_RECIP = 21'd1118482;
    localparam int          FRAC_SHIFT = 17;

    // hue sector, sixty degrees each
    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    // input item
    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] brightness;
    } hsv_in_t;

    // result item
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } rgb_out_t;

    // after hue split and clamping
    typedef struct packed {
        sector_t     sector;
        logic [12:0] rem;
        logic [16:0] sat;
        logic [16:0] val;
    } split_t;

    // channel candidates handed to the output mux
    typedef struct packed {
        sector_t     sector;
        logic [16:0] v;
        logic [16:0] p;
        logic [16:0] q;
        logic [16:0] t;
    } chan_set_t;

endpackage

`default_nettype wire

### hw/rtl/hsv2rgb_split.sv
// ---------------------------------------------------------------------------
// hsv2rgb_split
// First stage: folds the hue, splits it into sector and remainder, and
// clamps saturation and brightness to one.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_split (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire hsv2rgb_pkg::hsv_in_t  in_item,
    output logic                       out_valid,
    output hsv2rgb_pkg::split_t        out_item
);

    logic                 valid_reg;
    hsv2rgb_pkg::split_t  item_reg;
    hsv2rgb_pkg::split_t  item_next;

    logic [15:0] hue_fold;
    logic [15:0] base;

    // hue fold and sector search over five thresholds
    always_comb begin
        hue_fold = (in_item.hue >= hsv2rgb_pkg::HUE_FULL) ? 16'd0 : in_item.hue;
        if (hue_fold >= 16'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
            item_next.sector = hsv2rgb_pkg::SECT_MAG_RED;
            base             = 16'(5 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (hue_fold >= 16'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
            item_next.sector = hsv2rgb_pkg::SECT_BLU_MAG;
            base             = 16'(4 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (hue_fold >= 16'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
            item_next.sector = hsv2rgb_pkg::SECT_CYN_BLU;
            base             = 16'(3 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (hue_fold >= 16'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
            item_next.sector = hsv2rgb_pkg::SECT_GRN_CYN;
            base             = 16'(2 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (hue_fold >= hsv2rgb_pkg::HUE_SECTOR) begin
            item_next.sector = hsv2rgb_pkg::SECT_YEL_GRN;
            base             = hsv2rgb_pkg::HUE_SECTOR;
        end else begin
            item_next.sector = hsv2rgb_pkg::SECT_RED_YEL;
            base             = 16'd0;
        end
        item_next.rem = 13'(hue_fold - base);
        // clamp to one
        item_next.sat = (in_item.saturation > hsv2rgb_pkg::ONE_Q16) ?
                        hsv2rgb_pkg::ONE_Q16 : in_item.saturation;
        item_next.val = (in_item.brightness > hsv2rgb_pkg::ONE_Q16) ?
                        hsv2rgb_pkg::ONE_Q16 : in_item.brightness;
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### hw/rtl/hsv2rgb_prod.sv
// ---------------------------------------------------------------------------
// hsv2rgb_prod
// Three multiplier stages: fraction and p, then s*f and s*(1-f), then q
// and t.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_prod (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [2:0]             en,
    input  wire logic                   in_valid,
    input  wire hsv2rgb_pkg::split_t    in_item,
    output logic [2:0]                  stage_valid,
    output hsv2rgb_pkg::chan_set_t      out_item
);

    logic [2:0] valid_reg;

    // stage a: fraction and p
    hsv2rgb_pkg::sector_t sect_a_reg;
    logic [15:0]          frac_a_reg, frac_a_next;
    logic [16:0]          sat_a_reg;
    logic [16:0]          val_a_reg;
    logic [16:0]          p_a_reg, p_a_next;
    logic [33:0]          frac_prod;
    logic [33:0]          p_prod;

    // stage b: s*f and s*(1-f)
    hsv2rgb_pkg::sector_t sect_b_reg;
    logic [16:0]          val_b_reg;
    logic [16:0]          p_b_reg;
    logic [15:0]          sf_b_reg, sf_b_next;
    logic [16:0]          sg_b_reg, sg_b_next;
    logic [32:0]          sf_prod;
    logic [33:0]          sg_prod;

    // stage c: q and t
    hsv2rgb_pkg::chan_set_t set_c_reg;
    logic [16:0]            q_c_next, t_c_next;
    logic [33:0]            q_prod;
    logic [33:0]            t_prod;

    // fraction by reciprocal multiply, p = v(1-s)
    always_comb begin
        frac_prod  = 34'(in_item.rem) * 34'(hsv2rgb_pkg::FRAC_RECIP);
        frac_a_next = frac_prod[hsv2rgb_pkg::FRAC_SHIFT +: 16];
        p_prod     = 34'(in_item.val) * 34'(hsv2rgb_pkg::ONE_Q16 - in_item.sat);
        p_a_next   = p_prod[32:16];
    end

    // s*f and s*(1-f)
    always_comb begin
        sf_prod   = 33'(sat_a_reg) * 33'(frac_a_reg);
        sf_b_next = sf_prod[31:16];
        sg_prod   = 34'(sat_a_reg) * 34'(hsv2rgb_pkg::ONE_Q16 - {1'b0, frac_a_reg});
        sg_b_next = sg_prod[32:16];
    end

    // q = v(1-sf), t = v(1-sg)
    always_comb begin
        q_prod   = 34'(val_b_reg) * 34'(hsv2rgb_pkg::ONE_Q16 - {1'b0, sf_b_reg});
        q_c_next = q_prod[32:16];
        t_prod   = 34'(val_b_reg) * 34'(hsv2rgb_pkg::ONE_Q16 - sg_b_reg);
        t_c_next = t_prod[32:16];
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 3'b000;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (en[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2]) begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sect_a_reg <= in_item.sector;
            frac_a_reg <= frac_a_next;
            sat_a_reg  <= in_item.sat;
            val_a_reg  <= in_item.val;
            p_a_reg    <= p_a_next;
        end
        if (en[1]) begin
            sect_b_reg <= sect_a_reg;
            val_b_reg  <= val_a_reg;
            p_b_reg    <= p_a_reg;
            sf_b_reg   <= sf_b_next;
            sg_b_reg   <= sg_b_next;
        end
        if (en[2]) begin
            set_c_reg.sector <= sect_b_reg;
            set_c_reg.v      <= val_b_reg;
            set_c_reg.p      <= p_b_reg;
            set_c_reg.q      <= q_c_next;
            set_c_reg.t      <= t_c_next;
        end
    end

    assign stage_valid = valid_reg;
    assign out_item    = set_c_reg;

endmodule

`default_nettype wire

### hw/rtl/hsv2rgb_mux.sv
// ---------------------------------------------------------------------------
// hsv2rgb_mux
// Output stage: sector mux of v, p, q and t onto the channels, scaling by
// 65535/65536, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mux (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire hsv2rgb_pkg::chan_set_t  in_item,
    output logic                         out_valid,
    output hsv2rgb_pkg::rgb_out_t        out_item
);

    logic                   valid_reg;
    hsv2rgb_pkg::rgb_out_t  item_reg;
    hsv2rgb_pkg::rgb_out_t  item_next;
    logic [16:0]            r_sel, g_sel, b_sel;

    // floor(x * 65535 / 65536) is x - 1 for 0 < x <= 65536, else 0
    function automatic logic [15:0] scale_chan(input logic [16:0] x);
        logic [16:0] d;
        d = x - 17'(x != 17'd0);
        return d[15:0];
    endfunction

    // sector mux
    always_comb begin
        unique case (in_item.sector)
            hsv2rgb_pkg::SECT_RED_YEL: begin
                r_sel = in_item.v; g_sel = in_item.t; b_sel = in_item.p;
            end
            hsv2rgb_pkg::SECT_YEL_GRN: begin
                r_sel = in_item.q; g_sel = in_item.v; b_sel = in_item.p;
            end
            hsv2rgb_pkg::SECT_GRN_CYN: begin
                r_sel = in_item.p; g_sel = in_item.v; b_sel = in_item.t;
            end
            hsv2rgb_pkg::SECT_CYN_BLU: begin
                r_sel = in_item.p; g_sel = in_item.q; b_sel = in_item.v;
            end
            hsv2rgb_pkg::SECT_BLU_MAG: begin
                r_sel = in_item.t; g_sel = in_item.p; b_sel = in_item.v;
            end
            default: begin
                r_sel = in_item.v; g_sel = in_item.p; b_sel = in_item.q;
            end
        endcase
        item_next.red   = scale_chan(r_sel);
        item_next.green = scale_chan(g_sel);
        item_next.blue  = scale_chan(b_sel);
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### hw/rtl/hsv_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to 16-bit RGB color conversion, five-stage pipeline.
// ---------------------------------------------------------------------------
// One HSV item in, one RGB item out, no state between items. Hue is degrees
// times 128 (46080 and above reads as 0); saturation and brightness are
// unsigned Q0.16 where 65536 is 1.0 and larger values clamp to 1.0. The
// pipeline takes one item per clock while m_ready does not stall the output.
// An item passes five registers: hue split, fraction and p multiply, s*f and
// s*(1-f) multiply, q and t multiply, and the sector mux with the output
// register; m_valid rises once the item reaches the output register. Each
// stage stalls only when the stage after it is full, so empty slots close up
// while the output waits on m_ready.
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hsv2rgb_pkg::hsv_in_t   s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hsv2rgb_pkg::rgb_out_t       m_data
);

    logic                    split_valid;
    hsv2rgb_pkg::split_t     split_item;
    logic [2:0]              prod_valid;
    hsv2rgb_pkg::chan_set_t  prod_item;

    logic en_split;
    logic [2:0] en_prod;
    logic en_out;

    // per-stage load enables: a stage loads when it is empty or drains
    always_comb begin
        en_out     = !m_valid || m_ready;
        en_prod[2] = !prod_valid[2] || en_out;
        en_prod[1] = !prod_valid[1] || en_prod[2];
        en_prod[0] = !prod_valid[0] || en_prod[1];
        en_split   = !split_valid || en_prod[0];
    end

    assign s_ready = en_split;

    hsv2rgb_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_split),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .out_valid (split_valid),
        .out_item  (split_item)
    );

    hsv2rgb_prod u_prod (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en_prod),
        .in_valid    (split_valid),
        .in_item     (split_item),
        .stage_valid (prod_valid),
        .out_item    (prod_item)
    );

    hsv2rgb_mux u_mux (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_out),
        .in_valid  (prod_valid[2]),
        .in_item   (prod_item),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

`ifndef SYNTHESIS
    // an empty output register means the whole pipe can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output register empty");

    // reset leaves no item in flight
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !split_valid && prod_valid == 3'b000))
        else $error("pipeline valid bits not cleared by reset");

    // a stalled output keeps the last product stage from loading over it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && prod_valid[2]) |-> !en_prod[2])
        else $error("last product stage overwritten during output stall");
`endif

endmodule

`default_nettype wire
